// File: sv/fpc_pkg.sv
//------------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the frustum plane cull block.
//------------------------------------------------------------------------------
package fpc_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_PLANES = 6;

    typedef logic [2:0] plane_idx_t;

    typedef struct packed {
        logic       ld_elem;
        logic [3:0] ld_index;
        logic       build_start;
        logic       test_start;
    } fpc_cmd_t;

    typedef struct packed {
        logic build_done;
        logic test_done;
        logic test_inside;
    } fpc_status_t;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) r = 32'h7fffffff;
        else if (v < -34'sd2147483648) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// File: sv/fpc_if.sv
//------------------------------------------------------------------------------
// fpc_in_if / fpc_out_if
// Valid/ready channels carrying the input word and the result word.
//------------------------------------------------------------------------------
interface fpc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0] radius;
    modport source (output valid, kind, elem_index, elem_value, center_x, center_y,
                    center_z, radius, input ready);
    modport sink (input valid, kind, elem_index, elem_value, center_x, center_y,
                  center_z, radius, output ready);
endinterface

interface fpc_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface

// File: sv/fpc_datapath.sv
//------------------------------------------------------------------------------
// fpc_datapath
// Matrix store, plane build unit (isqrt and divider) and dot-product tester.
//------------------------------------------------------------------------------
module fpc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fpc_pkg::fpc_cmd_t  cmd,
    input  logic signed [31:0] elem_value,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    output fpc_pkg::fpc_status_t status
);
    import fpc_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_SUMS, B_SQ, B_SQRT, B_CHK, B_DIV, B_WR, B_NEXT
    } bstate_t;
    typedef enum logic [2:0] {T_IDLE, T_MUL, T_ACC, T_CMP, T_DONE} tstate_t;

    localparam int DIVW = 32 + FRAC_BITS;

    logic signed [31:0] mat_reg [16];
    logic signed [31:0] nrm_reg [18];
    logic signed [31:0] ofs_reg [6];

    bstate_t    bst_reg;
    plane_idx_t bp_reg;
    logic [1:0] k_reg;
    logic [1:0] dk_reg;
    logic signed [31:0] v_reg [4];
    logic [63:0] sumsq_reg;
    logic [63:0] sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [31:0] len_reg;
    logic [DIVW-1:0] dv_rem_reg, dv_q_reg;
    logic [63:0] dv_num_reg;
    logic [5:0] dv_cnt_reg;
    logic        dv_neg_reg;
    logic        bdone_reg;

    logic [1:0] col;
    logic       sgn_neg;
    always_comb
    begin
        unique case (bp_reg)
            3'd0: begin col = 2'd0; sgn_neg = 1'b1; end
            3'd1: begin col = 2'd0; sgn_neg = 1'b0; end
            3'd2: begin col = 2'd1; sgn_neg = 1'b0; end
            3'd3: begin col = 2'd1; sgn_neg = 1'b1; end
            3'd4: begin col = 2'd2; sgn_neg = 1'b1; end
            default: begin col = 2'd2; sgn_neg = 1'b0; end
        endcase
    end

    logic signed [31:0] ea, eb;
    logic signed [33:0] esum;
    logic signed [63:0] sqp;
    logic [64:0] sq_trial;
    logic [31:0] dv_mag;
    logic [DIVW:0] dv_trial;
    logic [DIVW-1:0] qfin;
    logic [31:0] qsat;
    always_comb
    begin
        ea = mat_reg[{k_reg, 2'd3}];
        eb = mat_reg[{k_reg, col}];
        esum = sgn_neg ? (34'(ea) - 34'(eb)) : (34'(ea) + 34'(eb));
        sqp = 64'(v_reg[dk_reg]) * 64'(v_reg[dk_reg]);
        sq_trial = 65'(sq_res_reg) + 65'(sq_bit_reg);
        dv_mag = v_reg[dk_reg][31] ? 32'(-33'(v_reg[dk_reg])) : v_reg[dk_reg];
        dv_trial = {dv_rem_reg, dv_num_reg[63]} - (DIVW + 1)'(len_reg);
        qfin = dv_q_reg;
        if (dv_neg_reg)
            qsat = (qfin > DIVW'(33'h080000000)) ? 32'h80000000 : 32'(-qfin);
        else
            qsat = (qfin > DIVW'(32'h7fffffff)) ? 32'h7fffffff : qfin[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg <= B_IDLE;
            bdone_reg <= 1'b0;
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            for (int i = 0; i < 18; i++) nrm_reg[i] <= '0;
            for (int i = 0; i < 6; i++) ofs_reg[i] <= '0;
            bp_reg <= '0;
            k_reg <= '0;
            dk_reg <= '0;
        end
        else
        begin
            bdone_reg <= 1'b0;
            if (cmd.ld_elem) mat_reg[cmd.ld_index] <= elem_value;
            unique case (bst_reg)
                B_IDLE:
                begin
                    if (cmd.build_start)
                    begin
                        bp_reg <= '0;
                        k_reg <= '0;
                        bst_reg <= B_SUMS;
                    end
                end
                B_SUMS:
                begin
                    v_reg[k_reg] <= sat32(esum);
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        dk_reg <= '0;
                        sumsq_reg <= '0;
                        bst_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    sumsq_reg <= sumsq_reg + 64'(sqp);
                    dk_reg <= dk_reg + 2'd1;
                    if (dk_reg == 2'd2)
                    begin
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000000000000000;
                        sq_x_reg <= sumsq_reg + 64'(sqp);
                        bst_reg <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        len_reg <= sq_res_reg[31:0];
                        bst_reg <= B_CHK;
                    end
                    else
                    begin
                        if (65'(sq_x_reg) >= sq_trial)
                        begin
                            sq_x_reg <= sq_x_reg - sq_trial[63:0];
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                            sq_res_reg <= sq_res_reg >> 1;
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                B_CHK:
                begin
                    dk_reg <= '0;
                    if (len_reg == '0)
                    begin
                        for (int i = 0; i < 3; i++) nrm_reg[3 * bp_reg + i] <= '0;
                        ofs_reg[bp_reg] <= '0;
                        bst_reg <= B_NEXT;
                    end
                    else
                    begin
                        dv_num_reg <= '0;
                        bst_reg <= B_DIV;
                        dv_cnt_reg <= '0;
                    end
                end
                B_DIV:
                begin
                    if (dv_cnt_reg == '0)
                    begin
                        dv_neg_reg <= v_reg[dk_reg][31];
                        dv_num_reg <= 64'({dv_mag, FRAC_BITS'(0)}) << (64 - DIVW);
                        dv_rem_reg <= '0;
                        dv_q_reg <= '0;
                        dv_cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        if (!dv_trial[DIVW])
                        begin
                            dv_rem_reg <= dv_trial[DIVW-1:0];
                            dv_q_reg <= {dv_q_reg[DIVW-2:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg <= {dv_rem_reg[DIVW-2:0], dv_num_reg[63]};
                            dv_q_reg <= {dv_q_reg[DIVW-2:0], 1'b0};
                        end
                        dv_num_reg <= dv_num_reg << 1;
                        dv_cnt_reg <= dv_cnt_reg + 6'd1;
                        if (dv_cnt_reg == 6'(DIVW)) bst_reg <= B_WR;
                    end
                end
                B_WR:
                begin
                    if (dk_reg == 2'd3) ofs_reg[bp_reg] <= qsat;
                    else nrm_reg[3 * bp_reg + dk_reg] <= qsat;
                    dk_reg <= dk_reg + 2'd1;
                    dv_cnt_reg <= '0;
                    bst_reg <= (dk_reg == 2'd3) ? B_NEXT : B_DIV;
                end
                default:
                begin
                    k_reg <= '0;
                    bp_reg <= bp_reg + 3'd1;
                    if (bp_reg == 3'(NUM_PLANES - 1))
                    begin
                        bdone_reg <= 1'b1;
                        bst_reg <= B_IDLE;
                    end
                    else
                        bst_reg <= B_SUMS;
                end
            endcase
        end
    end

    // Offset column sum uses row 3: reuse the sums path with k = 3 (w row).
    // v_reg[3] holds m15 +/- m(12+c), as row 3 addresses elements 12..15.

    tstate_t tst_reg;
    plane_idx_t tp_reg;
    logic [1:0] tk_reg;
    logic signed [63:0] prod_reg, dot_reg;
    logic        out_reg, tdone_reg, hit_reg;
    logic signed [31:0] tcx_reg, tcy_reg, tcz_reg;
    logic [30:0] trad_reg;
    logic signed [31:0] cx;
    logic signed [63:0] lim;
    always_comb
    begin
        unique case (tk_reg)
            2'd0: cx = tcx_reg;
            2'd1: cx = tcy_reg;
            default: cx = tcz_reg;
        endcase
        lim = -((64'(ofs_reg[tp_reg]) + 64'(trad_reg)) <<< FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tst_reg <= T_IDLE;
            tdone_reg <= 1'b0;
            out_reg <= 1'b0;
            hit_reg <= 1'b0;
            tp_reg <= '0;
            tk_reg <= '0;
            tcx_reg <= '0;
            tcy_reg <= '0;
            tcz_reg <= '0;
            trad_reg <= '0;
        end
        else
        begin
            tdone_reg <= 1'b0;
            unique case (tst_reg)
                T_IDLE:
                begin
                    if (cmd.test_start)
                    begin
                        tcx_reg <= center_x;
                        tcy_reg <= center_y;
                        tcz_reg <= center_z;
                        trad_reg <= radius;
                        tp_reg <= '0;
                        tk_reg <= '0;
                        dot_reg <= '0;
                        hit_reg <= 1'b0;
                        tst_reg <= T_MUL;
                    end
                end
                T_MUL:
                begin
                    prod_reg <= 64'(nrm_reg[3 * tp_reg + tk_reg]) * 64'(cx);
                    tst_reg <= T_ACC;
                end
                T_ACC:
                begin
                    dot_reg <= dot_reg + prod_reg;
                    tk_reg <= tk_reg + 2'd1;
                    tst_reg <= (tk_reg == 2'd2) ? T_CMP : T_MUL;
                end
                T_CMP:
                begin
                    tk_reg <= '0;
                    dot_reg <= '0;
                    if (dot_reg <= lim) hit_reg <= 1'b1;
                    tp_reg <= tp_reg + 3'd1;
                    tst_reg <= (tp_reg == 3'(NUM_PLANES - 1)) ? T_DONE : T_MUL;
                end
                default:
                begin
                    out_reg <= !hit_reg;
                    tdone_reg <= 1'b1;
                    tst_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign status.build_done = bdone_reg;
    assign status.test_done = tdone_reg;
    assign status.test_inside = out_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(bst_reg != B_IDLE && tst_reg != T_IDLE)) else $error("build and test overlap");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        status.test_done |=> !status.test_done) else $error("double test done");
    a_len_div: assert property (@(posedge clk) disable iff (!rst_n)
        bst_reg == B_DIV |-> len_reg != '0) else $error("divide by zero length");
`endif
endmodule

// File: sv/fpc_ctrl.sv
//------------------------------------------------------------------------------
// fpc_ctrl
// Handshake controller: takes one word, issues commands, holds the result.
//------------------------------------------------------------------------------
module fpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    fpc_in_if.sink               in_ch,
    fpc_out_if.source            out_ch,
    input  fpc_pkg::fpc_status_t status,
    output fpc_pkg::fpc_cmd_t    cmd
);
    import fpc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_BUILD, S_TEST, S_OUT} state_t;
    state_t state_reg;
    logic   res_reg;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.inside_res = res_reg;

    always_comb
    begin
        cmd.ld_elem = acc && !in_ch.kind;
        cmd.ld_index = in_ch.elem_index;
        cmd.build_start = acc && !in_ch.kind && (in_ch.elem_index == 4'd15);
        cmd.test_start = acc && in_ch.kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.test_start) state_reg <= S_TEST;
                    else if (cmd.build_start) state_reg <= S_BUILD;
                end
                S_BUILD: if (status.build_done) state_reg <= S_IDLE;
                S_TEST:
                begin
                    if (status.test_done)
                    begin
                        res_reg <= status.test_inside;
                        state_reg <= S_OUT;
                    end
                end
                default: if (out_ch.ready) state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result dropped");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
    a_test: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.test_start |=> state_reg == S_TEST) else $error("test not started");
`endif
endmodule

// File: sv/frustum_plane_cull.sv
//------------------------------------------------------------------------------
// frustum_plane_cull
// Six-plane frustum extraction from a clip matrix and sphere culling test.
//------------------------------------------------------------------------------
// Sphere test: after accept the datapath steps through T_MUL, T_ACC and T_CMP (one shared 32x32 multiplier,
// a multiply and an accumulate state per term and a compare state per plane);
// the next word is taken in the cycle after the result goes, never while a test is pending.
// Element load writes the matrix store on accept; element 15 starts the plane build,
// paced by the bit-serial square root and the 48-step divider per component.
// Reset (rst_n, asynchronous) clears the matrix and all planes to zero.
//------------------------------------------------------------------------------
module frustum_plane_cull (
    input  logic      clk,
    input  logic      rst_n,
    fpc_in_if.sink    in_ch,
    fpc_out_if.source out_ch
);
    import fpc_pkg::*;

    fpc_cmd_t    cmd;
    fpc_status_t status;

    fpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .status (status),
        .cmd    (cmd)
    );

    fpc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .elem_value (in_ch.elem_value),
        .center_x   (in_ch.center_x),
        .center_y   (in_ch.center_y),
        .center_z   (in_ch.center_z),
        .radius     (in_ch.radius),
        .status     (status)
    );
endmodule
